/* rtl/htfd_pkg.sv */
// htfd_pkg: shared types, constants and the crc-8 byte update for the
// humidity/temperature frame decoder. No dependencies.
package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte positions within one sensor frame
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  typedef struct packed {
    logic        status;
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
  } word_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/htfd_if.sv */
// htfd_if: valid/ready channel interfaces for frame bytes and decoded results.
// No dependencies.
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink (input valid, data_byte, frame_start, output ready);
endinterface

interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic        [15:0] temperature_raw;
  logic        [15:0] humidity_raw;

  modport source (output valid, status, temperature_centi, humidity_centi,
                  temperature_raw, humidity_raw, input ready);
  modport sink (input valid, status, temperature_centi, humidity_centi,
                temperature_raw, humidity_raw, output ready);
endinterface

/* rtl/htfd_frame.sv */
// htfd_frame: byte position tracking, crc-8 checks and word capture.
// Depends on htfd_pkg and htfd_in_if.
module htfd_frame (
  input  logic           clk,
  input  logic           rst,
  htfd_in_if.sink        frame,
  input  logic           pass,
  output logic           word_valid,
  output htfd_pkg::word_t word
);

  logic [2:0]  pos;
  logic [2:0]  pos_next;
  logic [2:0]  pos_eff;
  logic [7:0]  crc;
  logic [7:0]  crc_next;
  logic [15:0] tword;
  logic [15:0] tword_next;
  logic        tok;
  logic        tok_next;
  logic [7:0]  hhi;
  logic [7:0]  hhi_next;
  logic [7:0]  hlo;
  logic [7:0]  hlo_next;
  logic        accept;

  assign frame.ready = pass;
  assign accept      = frame.valid && pass;

  always_comb begin
    if (frame.frame_start || pos > htfd_pkg::POS_H_CRC) begin
      pos_eff = htfd_pkg::POS_T_HI;
    end else begin
      pos_eff = pos;
    end
  end

  always_comb begin
    pos_next   = pos_eff + 3'd1;
    crc_next   = crc;
    tword_next = tword;
    tok_next   = tok;
    hhi_next   = hhi;
    hlo_next   = hlo;
    unique case (pos_eff)
      htfd_pkg::POS_T_HI: begin
        tword_next = {frame.data_byte, 8'h00};
        crc_next   = htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, frame.data_byte);
      end
      htfd_pkg::POS_T_LO: begin
        tword_next = {tword[15:8], frame.data_byte};
        crc_next   = htfd_pkg::crc_byte(crc, frame.data_byte);
      end
      htfd_pkg::POS_T_CRC: begin
        tok_next = (crc == frame.data_byte);
        crc_next = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_H_HI: begin
        hhi_next = frame.data_byte;
        crc_next = htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, frame.data_byte);
      end
      htfd_pkg::POS_H_LO: begin
        hlo_next = frame.data_byte;
        crc_next = htfd_pkg::crc_byte(crc, frame.data_byte);
      end
      default: begin
        crc_next = htfd_pkg::CRC_INIT;
        pos_next = htfd_pkg::POS_T_HI;
      end
    endcase
  end

  assign word_valid           = accept && (pos_eff == htfd_pkg::POS_H_CRC);
  assign word.status          = !(tok && (crc == frame.data_byte));
  assign word.temperature_raw = tword;
  assign word.humidity_raw    = {hhi, hlo};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= htfd_pkg::POS_T_HI;
      crc   <= htfd_pkg::CRC_INIT;
      tword <= 16'h0000;
      tok   <= 1'b0;
      hhi   <= 8'h00;
      hlo   <= 8'h00;
    end else if (accept) begin
      pos   <= pos_next;
      crc   <= crc_next;
      tword <= tword_next;
      tok   <= tok_next;
      hhi   <= hhi_next;
      hlo   <= hlo_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= htfd_pkg::POS_H_CRC)
    else $error("frame position out of range");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    word_valid |=> (pos == htfd_pkg::POS_T_HI) && (crc == htfd_pkg::CRC_INIT))
    else $error("frame did not restart after last byte");

  a_tcrc_reload: assert property (@(posedge clk) disable iff (rst)
    accept && (pos_eff == htfd_pkg::POS_T_CRC) |=>
      (crc == htfd_pkg::CRC_INIT) && (pos == htfd_pkg::POS_H_HI))
    else $error("crc not reloaded after temperature check byte");
`endif

endmodule

/* rtl/htfd_scale.sv */
// htfd_scale: product stage and divide-by-65535 output stage for the
// decoded words. Depends on htfd_pkg and htfd_out_if.
module htfd_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            word_valid,
  input  htfd_pkg::word_t word,
  output logic            pass,
  htfd_out_if.source      result
);

  logic        v1;
  logic        status1;
  logic [15:0] traw1;
  logic [15:0] hraw1;
  logic [30:0] tprod;
  logic [29:0] hprod;
  logic [31:0] tsum;
  logic [30:0] hsum;
  logic [14:0] tq;
  logic [13:0] hq;
  logic        adv_out;

  assign adv_out = !result.valid || result.ready;
  assign pass    = !v1 || adv_out;

  // x / 65535 as (x + (x >> 16) + 1) >> 16, exact for x below 2^32 - 1
  assign tsum = 32'(tprod) + 32'(tprod[30:16]) + 32'd1;
  assign hsum = 31'(hprod) + 31'(hprod[29:16]) + 31'd1;
  assign tq   = tsum[30:16];
  assign hq   = hsum[29:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (word_valid) begin
      v1 <= 1'b1;
    end else if (adv_out) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid) begin
      status1 <= word.status;
      traw1   <= word.temperature_raw;
      hraw1   <= word.humidity_raw;
      tprod   <= 31'(word.temperature_raw) * 31'(htfd_pkg::TEMP_SCALE);
      hprod   <= 30'(word.humidity_raw) * 30'(htfd_pkg::HUM_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv_out) begin
      result.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && v1) begin
      result.status            <= status1;
      result.temperature_centi <= $signed(tq - htfd_pkg::TEMP_OFFSET);
      result.humidity_centi    <= hq;
      result.temperature_raw   <= traw1;
      result.humidity_raw      <= hraw1;
    end
  end

`ifndef SYNTHESIS
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !adv_out |=> v1 && $stable(traw1) && $stable(hraw1) && $stable(status1))
    else $error("product stage lost while output stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> pass)
    else $error("word loaded into occupied product stage");
`endif

endmodule

/* rtl/humidity_temp_frame_decoder.sv */
// humidity_temp_frame_decoder: six-byte sensor frame decoder with crc-8 checks.
// The sixth byte's word is registered into the product stage, then into the output registers for the result.
// Throughput: one byte per cycle unless the output stalls with both the product and output registers full.
// Reset (rst, synchronous): position to byte zero, crc to 0xFF, pipeline empty.
// Depends on htfd_pkg, htfd_if, htfd_frame and htfd_scale.
module humidity_temp_frame_decoder (
  input  logic       clk,
  input  logic       rst,
  htfd_in_if.sink    frame,
  htfd_out_if.source result
);

  logic            pass;
  logic            word_valid;
  htfd_pkg::word_t word;

  htfd_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .pass       (pass),
    .word_valid (word_valid),
    .word       (word)
  );

  htfd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .pass       (pass),
    .result     (result)
  );

endmodule
